>>> rtl/ssi_pkg.sv
// package for the sorted set insert and lookup block
// shared widths, defaults, mode code and the cell status type
// no dependencies
`default_nettype none

package ssi_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;

  localparam int KEY_W = 32;
  localparam int POS_W = 7;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_ADD    = 1'b1;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_stat_t;

endpackage

`default_nettype wire

>>> rtl/ssi_if.sv
// valid/ready channel interfaces for request and response transfers
// depends on ssi_pkg for field widths
`default_nettype none

interface ssi_req_if;
  import ssi_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface ssi_rsp_if;
  import ssi_pkg::*;

  logic             valid;
  logic             ready;
  logic             present;
  logic             inserted;
  logic             full_reject;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] count;

  modport source (output valid, output present, output inserted, output full_reject,
                  output position, output count, input ready);
  modport sink   (input valid, input present, input inserted, input full_reject,
                  input position, input count, output ready);
endinterface

`default_nettype wire

>>> rtl/sorted_set_insert_lookup.sv
// top level of the sorted set: row of key cells, position encoder, count and result register
// depends on ssi_pkg, ssi_req_if, ssi_rsp_if and ssi_cell
`default_nettype none

// Holds up to CAPACITY distinct signed keys in ascending order, one key per cell.
// A request transfer either looks a key up or adds it; every cell compares its key
// with the request in the same cycle, and an add shifts the larger keys one cell up
// in that cycle. One request is taken per clock while no held response is stalled,
// and its response stands in the output register from the next cycle on; a new
// request is taken while the held response leaves in the same cycle. No clearing
// pass follows reset: cells above the key count are never looked at.
module sorted_set_insert_lookup #(
  parameter int CAPACITY = ssi_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = ssi_pkg::KEY_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ssi_req_if.sink    req,
  ssi_rsp_if.source  rsp
);
  import ssi_pkg::*;

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  logic [KEY_BITS-1:0] key_ext;
  logic [KEY_BITS-1:0] key_b;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  logic [CNT_BITS-1:0] pos;
  logic                acc;
  logic                present;
  logic                full;
  logic                do_ins;
  logic                full_rej;
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] bnd;
  logic [KEY_BITS-1:0] entry [CAPACITY];
  cell_stat_t          stat  [CAPACITY];

  generate
    if (KEY_BITS <= KEY_W) begin : g_key_narrow
      assign key_ext = req.key[KEY_BITS-1:0];
    end else begin : g_key_wide
      assign key_ext = {{(KEY_BITS-KEY_W){req.key[KEY_W-1]}}, req.key};
    end
  endgenerate

  assign key_b = key_ext ^ {1'b1, {(KEY_BITS-1){1'b0}}};

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                left_lt;
      logic [KEY_BITS-1:0] left_entry;
      if (i == 0) begin : g_first
        assign left_lt    = 1'b1;
        assign left_entry = key_b;
      end else begin : g_rest
        assign left_lt    = lt[i-1];
        assign left_entry = entry[i-1];
      end
      ssi_cell #(
        .KEY_BITS (KEY_BITS),
        .CNT_BITS (CNT_BITS),
        .INDEX    (i)
      ) u_cell (
        .clk        (clk),
        .key        (key_b),
        .count      (count),
        .wr         (do_ins),
        .left_lt    (left_lt),
        .left_entry (left_entry),
        .stat       (stat[i]),
        .entry      (entry[i])
      );
      assign lt[i]  = stat[i].lt;
      assign eq[i]  = stat[i].eq;
      assign bnd[i] = !lt[i] && left_lt;
    end
  endgenerate

  // boundary cell is the first one not below the key
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos = pos | (bnd[i] ? CNT_BITS'(i) : '0);
    end
    if (lt[CAPACITY-1]) begin
      pos = CNT_BITS'(CAPACITY);
    end
  end

  assign acc        = req.valid && req.ready;
  assign present    = |(bnd & eq);
  assign full       = count == CNT_BITS'(CAPACITY);
  assign do_ins     = acc && (req.mode == MODE_ADD) && !present && !full;
  assign full_rej   = (req.mode == MODE_ADD) && !present && full;
  assign count_next = count + CNT_BITS'(do_ins);

  assign req.ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (acc) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.present     <= present;
      rsp.inserted    <= do_ins;
      rsp.full_reject <= full_rej;
      rsp.position    <= POS_W'(pos);
      rsp.count       <= POS_W'(count_next);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(CAPACITY))
    else $error("key count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_ins |=> count == $past(count) + CNT_BITS'(1))
    else $error("insert did not grow the key count");

  a_sorted_row: assert property (@(posedge clk) disable iff (rst)
    $onehot0(bnd))
    else $error("stored keys out of order");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.inserted |-> !rsp.present && !rsp.full_reject)
    else $error("inserted response with present or full flag");

endmodule

`default_nettype wire

>>> rtl/ssi_cell.sv
// one slot of the sorted row: holds a biased key, compares it with the search key
// and on insert keeps, takes the new key or takes its left neighbor; uses ssi_pkg
`default_nettype none

module ssi_cell #(
  parameter int KEY_BITS = 32,
  parameter int CNT_BITS = 7,
  parameter int INDEX    = 0
) (
  input  wire logic                 clk,
  input  wire logic [KEY_BITS-1:0]  key,
  input  wire logic [CNT_BITS-1:0]  count,
  input  wire logic                 wr,
  input  wire logic                 left_lt,
  input  wire logic [KEY_BITS-1:0]  left_entry,
  output ssi_pkg::cell_stat_t       stat,
  output logic      [KEY_BITS-1:0]  entry
);
  import ssi_pkg::*;

  logic occ;

  assign occ     = count > CNT_BITS'(INDEX);
  assign stat.lt = occ && (entry < key);
  assign stat.eq = occ && (entry == key);

  always_ff @(posedge clk) begin
    if (wr && !stat.lt) begin
      if (left_lt) begin
        entry <= key;
      end else begin
        entry <= left_entry;
      end
    end
  end

endmodule

`default_nettype wire

>>> sim/sorted_set_insert_lookup_checker.sv
// checker for the sorted set: keeps its own copy of the key table, predicts each response
// and compares every response transfer with the oldest prediction
// depends on ssi_pkg and the ssi_req_if / ssi_rsp_if interfaces
`timescale 1ns / 1ps

module sorted_set_insert_lookup_checker #(
  parameter int CAPACITY = ssi_pkg::CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  ssi_req_if        req,
  ssi_rsp_if        rsp,
  output int        mismatch_count,
  output int        pending_count
);
  import ssi_pkg::*;

  typedef struct packed {
    logic             present;
    logic             inserted;
    logic             full_reject;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] count;
  } set_result_t;

  logic signed [KEY_W-1:0] set_keys [CAPACITY];
  int                      n_keys = 0;
  int                      n_bad = 0;
  set_result_t             result_q [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic set_result_t apply_item(input logic m, input logic signed [KEY_W-1:0] k);
    set_result_t r;
    int          pos;
    r   = '0;
    pos = 0;
    while (pos < n_keys && set_keys[pos] < k) pos++;
    r.present = (pos < n_keys) && (set_keys[pos] == k);
    if (m == MODE_ADD && !r.present) begin
      if (n_keys >= CAPACITY) begin
        r.full_reject = 1'b1;
      end else begin
        // larger keys move up one slot
        for (int i = n_keys; i > pos; i--) set_keys[i] = set_keys[i-1];
        set_keys[pos] = k;
        n_keys++;
        r.inserted = 1'b1;
      end
    end
    r.position = pos[POS_W-1:0];
    r.count    = n_keys[POS_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    set_result_t got;
    set_result_t want;
    if (rst) begin
      n_keys = 0;
      result_q.delete();
    end else begin
      if (req.valid && req.ready) result_q.push_back(apply_item(req.mode, req.key));
      if (rsp.valid && rsp.ready) begin
        got = {rsp.present, rsp.inserted, rsp.full_reject, rsp.position, rsp.count};
        if (result_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: response with nothing outstanding: %s%0b %s%0b %s%0b %s%0d %s%0d",
                     $realtime, "present=", got.present, "inserted=", got.inserted,
                     "full=", got.full_reject, "pos=", got.position, "count=", got.count);
        end else begin
          want = result_q.pop_front();
          if (got.present !== want.present || got.inserted !== want.inserted ||
              got.full_reject !== want.full_reject || got.position !== want.position ||
              got.count !== want.count) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: mismatch exp present=%0b inserted=%0b full=%0b pos=%0d count=%0d",
                       $realtime, want.present, want.inserted, want.full_reject,
                       want.position, want.count);
              $display("%0t:          got present=%0b inserted=%0b full=%0b pos=%0d count=%0d",
                       $realtime, got.present, got.inserted, got.full_reject,
                       got.position, got.count);
            end
          end
        end
      end
    end
    mismatch_count <= n_bad;
    pending_count  <= result_q.size();
  end

endmodule

>>> sim/sorted_set_insert_lookup_tb.sv
// top of the sorted set testbench: clock, reset, request stimulus and response back-pressure
// depends on ssi_pkg, the ssi interfaces, the block and sorted_set_insert_lookup_checker
`timescale 1ns / 1ps

module sorted_set_insert_lookup_tb;
  import ssi_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   cycles = 0;
  int   phase;
  int   n_sent;

  logic signed [KEY_W-1:0] used_keys [$];

  ssi_req_if req ();
  ssi_rsp_if rsp ();

  sorted_set_insert_lookup i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  sorted_set_insert_lookup_checker i_check (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .rsp            (rsp),
    .mismatch_count (mismatches),
    .pending_count  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("FAIL sorted_set_insert_lookup");
      $finish;
    end
  end

  function automatic int send_idle_pct(input int ph);
    return (ph == 0) ? 34 : (ph == 1) ? 64 : 0;
  endfunction

  function automatic int recv_idle_pct(input int ph);
    return (ph == 0) ? 64 : (ph == 1) ? 34 : 0;
  endfunction

  always @(posedge clk) rsp.ready <= ($urandom_range(99, 0) >= recv_idle_pct(phase));

  task automatic send_item(input logic m, input logic signed [KEY_W-1:0] k);
    while ($urandom_range(99, 0) < send_idle_pct(phase)) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode  <= m;
    req.key   <= k;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    used_keys.push_back(k);
    n_sent++;
    phase <= (n_sent < 200) ? 0 : (n_sent < 400) ? 1 : 2;
  endtask

  // mix of repeats, near neighbors, extremes and fresh keys
  function automatic logic signed [KEY_W-1:0] pick_key();
    int                      sel;
    logic signed [KEY_W-1:0] k;
    sel = $urandom_range(99, 0);
    k   = $urandom;
    if (sel < 45 && used_keys.size() > 0) begin
      k = used_keys[$urandom_range(used_keys.size() - 1, 0)];
      if (sel >= 30) k = $urandom_range(1, 0) ? k + 1 : k - 1;
    end else if (sel < 52) begin
      case ($urandom_range(5, 0))
        0: k = KEY_MIN;
        1: k = KEY_MAX;
        2: k = '0;
        3: k = -1;
        4: k = KEY_MIN + 1;
        default: k = KEY_MAX - 1;
      endcase
    end
    return k;
  endfunction

  initial begin
    rst       = 1'b1;
    req.valid = 1'b0;
    req.mode  = MODE_LOOKUP;
    req.key   = '0;
    rsp.ready = 1'b0;
    phase     = 0;
    n_sent    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_item(MODE_LOOKUP, KEY_MIN);
    send_item(MODE_ADD, '0);
    send_item(MODE_ADD, KEY_MIN);
    send_item(MODE_ADD, KEY_MAX);
    send_item(MODE_ADD, -1);
    send_item(MODE_ADD, 1);
    send_item(MODE_ADD, '0);
    send_item(MODE_LOOKUP, KEY_MAX);
    send_item(MODE_LOOKUP, KEY_MIN);
    send_item(MODE_LOOKUP, 2);
    send_item(MODE_ADD, KEY_MIN + 1);
    send_item(MODE_ADD, KEY_MAX - 1);
    send_item(MODE_LOOKUP, KEY_MAX - 1);
    send_item(MODE_LOOKUP, -2);
    send_item(MODE_ADD, KEY_MAX);
    send_item(MODE_LOOKUP, 32'sh5555_5555);
    send_item(MODE_ADD, 32'shAAAA_AAAA);

    // adds fill the table part way through, then full rejects follow
    repeat (RANDOM_ITEMS)
      send_item(($urandom_range(99, 0) < 30) ? MODE_ADD : MODE_LOOKUP, pick_key());
    req.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS sorted_set_insert_lookup");
    else
      $display("FAIL sorted_set_insert_lookup");
    $finish;
  end

endmodule
